// File: hw/rtl/change_event_run_reporter_defines.svh
// Assertion macros used by the change-event run reporter checker (cerr_checker).
`ifndef CHANGE_EVENT_RUN_REPORTER_DEFINES_SVH
`define CHANGE_EVENT_RUN_REPORTER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CERR_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define CERR_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/cerr_pkg.sv
// ----------------------------------------------------------------------------
// cerr_pkg
// Types, op codes and default sizes of the change-event run reporter.
// ----------------------------------------------------------------------------
package cerr_pkg;

  // Default table geometry
  localparam int StatusBytesPerGroupDef = 4;
  localparam int StatusGroupsDef        = 2;
  localparam int ValueGroupsDef         = 2;
  localparam int MaxRunDef              = 16;

  // Fixed sizes
  localparam int ValuesPerGroup = 16;
  localparam int IvSpan         = 16;
  localparam int MaxResults     = 32;

  // Op codes
  localparam logic [2:0] OpStatusUpd  = 3'd0;
  localparam logic [2:0] OpValueUpd   = 3'd1;
  localparam logic [2:0] OpStatusScan = 3'd2;
  localparam logic [2:0] OpValueScan  = 3'd3;
  localparam logic [2:0] OpValidity   = 3'd4;

  typedef struct packed {
    logic [2:0]  op;
    logic [4:0]  index;
    logic [15:0] value;
  } item_t;

  typedef struct packed {
    logic       point_type;
    logic [5:0] first_index;
    logic [4:0] count;
    logic       last;
  } desc_t;

  typedef struct packed {
    logic st_write;
    logic val_write;
    logic scan_start;
    logic iv_start;
    logic scan_step;
    logic rep_step;
  } cmd_t;

  typedef struct packed {
    logic iv_hit;
    logic scan_stop;
    logic rep_last;
  } sts_t;

  typedef enum logic [2:0] {
    StIdle   = 3'b001,
    StScan   = 3'b010,
    StReport = 3'b100
  } state_e;

endpackage

// File: hw/rtl/cerr_ctrl.sv
// ----------------------------------------------------------------------------
// cerr_ctrl
// Sequencer: decodes accepted transactions and steps scans and group reports.
// ----------------------------------------------------------------------------
module cerr_ctrl import cerr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [2:0] op_i,
  input  sts_t       sts_i,
  output cmd_t       cmd_o,
  output logic       busy_o
);

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (start_i) begin
          case (op_i)
            OpStatusUpd: cmd_o.st_write = 1'b1;
            OpValueUpd:  cmd_o.val_write = 1'b1;
            OpStatusScan, OpValueScan: begin
              cmd_o.scan_start = 1'b1;
              state_d          = StScan;
            end
            OpValidity: begin
              if (sts_i.iv_hit) begin
                cmd_o.iv_start = 1'b1;
                state_d        = StReport;
              end
            end
            default: ;
          endcase
        end
      end
      StScan: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_stop) state_d = StIdle;
      end
      StReport: begin
        cmd_o.rep_step = 1'b1;
        if (sts_i.rep_last) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != StIdle);

endmodule

// File: hw/rtl/cerr_datapath.sv
// ----------------------------------------------------------------------------
// cerr_datapath
// Point tables, pending marks, scan walker, group reporter and result register.
// ----------------------------------------------------------------------------
module cerr_datapath import cerr_pkg::*; #(
  parameter int STATUS_BYTES_PER_GROUP = StatusBytesPerGroupDef,
  parameter int STATUS_GROUPS          = StatusGroupsDef,
  parameter int VALUE_GROUPS           = ValueGroupsDef,
  parameter int MAX_RUN                = MaxRunDef
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  item_t item_i,
  input  cmd_t  cmd_i,
  output sts_t  sts_o,
  output logic  result_valid_o,
  output desc_t result_o
);

  localparam int Spg    = STATUS_BYTES_PER_GROUP * 8;
  localparam int St     = Spg * STATUS_GROUPS;
  localparam int Sb     = STATUS_BYTES_PER_GROUP * STATUS_GROUPS;
  localparam int Vt     = ValuesPerGroup * VALUE_GROUPS;
  localparam int SbW    = $clog2(Sb);
  localparam int SidxW  = $clog2(St);
  localparam int VidxW  = $clog2(Vt);
  localparam int PtrW   = $clog2(((St > Vt) ? St : Vt) + 1);
  localparam int LeftW  = $clog2(((Spg > IvSpan) ? Spg : IvSpan) + 1);

  // Tables
  logic [7:0]               st_bits_q [Sb];
  logic [7:0]               st_bits_d [Sb];
  logic [St-1:0]            st_pend_q, st_pend_d;
  logic [STATUS_GROUPS-1:0] st_inv_q, st_inv_d;
  logic [15:0]              mv_q [Vt];
  logic [15:0]              mv_d [Vt];
  logic [Vt-1:0]            val_pend_q, val_pend_d;
  logic [VALUE_GROUPS-1:0]  val_inv_q, val_inv_d;

  // Scan and report state
  logic             type_q, type_d;
  logic [PtrW-1:0]  ptr_q, ptr_d;
  logic             run_open_q, run_open_d;
  logic [PtrW-1:0]  run_first_q, run_first_d;
  logic [4:0]       run_len_q, run_len_d;
  logic             held_valid_q, held_valid_d;
  logic [PtrW-1:0]  held_first_q, held_first_d;
  logic [4:0]       held_len_q, held_len_d;
  logic [5:0]       k_q, k_d;
  logic [5:0]       rep_pos_q, rep_pos_d;
  logic [LeftW-1:0] rep_left_q, rep_left_d;

  // Result register
  logic  out_valid_q, out_valid_d;
  desc_t out_q, out_d;

  logic             st_in_range, val_in_range;
  logic [7:0]       byte_change;
  logic             iv_flag, iv_hit, iv_type;
  logic [5:0]       iv_base;
  logic [LeftW-1:0] iv_left;
  logic [PtrW-1:0]  scan_size;
  logic             at_end, pend_bit, scan_stop;

  // Update and validity decode
  always_comb begin
    st_in_range  = (32'(item_i.index) < Sb);
    val_in_range = (32'(item_i.index) < Vt);
    byte_change  = st_bits_q[item_i.index[SbW-1:0]] ^ item_i.value[7:0];
    iv_flag      = item_i.value[0];
    iv_hit       = 1'b0;
    iv_type      = 1'b0;
    iv_base      = '0;
    iv_left      = LeftW'(Spg);
    for (int g = 0; g < STATUS_GROUPS; g++) begin
      if (item_i.index == 5'(g)) begin
        iv_hit  = (st_inv_q[g] != iv_flag);
        iv_base = 6'(g * Spg);
      end
    end
    for (int g = 0; g < VALUE_GROUPS; g++) begin
      if (item_i.index == 5'(g + 2)) begin
        iv_hit  = (val_inv_q[g] != iv_flag);
        iv_type = 1'b1;
        iv_base = 6'(g * ValuesPerGroup);
        iv_left = LeftW'(ValuesPerGroup);
      end
    end
  end

  // Scan walker status
  always_comb begin
    scan_size = type_q ? PtrW'(Vt) : PtrW'(St);
    at_end    = (ptr_q == scan_size);
    if (at_end) begin
      pend_bit = 1'b0;
    end else if (type_q) begin
      pend_bit = val_pend_q[ptr_q[VidxW-1:0]];
    end else begin
      pend_bit = st_pend_q[ptr_q[SidxW-1:0]];
    end
    scan_stop = !run_open_q && (at_end || (pend_bit && (k_q >= 6'(MaxResults))));
  end

  assign sts_o.iv_hit    = iv_hit;
  assign sts_o.scan_stop = scan_stop;
  assign sts_o.rep_last  = (rep_left_q <= LeftW'(IvSpan));

  always_comb begin
    st_bits_d    = st_bits_q;
    st_pend_d    = st_pend_q;
    st_inv_d     = st_inv_q;
    mv_d         = mv_q;
    val_pend_d   = val_pend_q;
    val_inv_d    = val_inv_q;
    type_d       = type_q;
    ptr_d        = ptr_q;
    run_open_d   = run_open_q;
    run_first_d  = run_first_q;
    run_len_d    = run_len_q;
    held_valid_d = held_valid_q;
    held_first_d = held_first_q;
    held_len_d   = held_len_q;
    k_d          = k_q;
    rep_pos_d    = rep_pos_q;
    rep_left_d   = rep_left_q;
    out_valid_d  = 1'b0;
    out_d        = out_q;

    if (cmd_i.st_write && st_in_range) begin
      st_bits_d[item_i.index[SbW-1:0]] = item_i.value[7:0];
      for (int b = 0; b < Sb; b++) begin
        if (item_i.index == 5'(b)) begin
          st_pend_d[b*8 +: 8] = st_pend_q[b*8 +: 8] | byte_change;
        end
      end
    end

    if (cmd_i.val_write && val_in_range &&
        (mv_q[item_i.index[VidxW-1:0]] != item_i.value)) begin
      mv_d[item_i.index[VidxW-1:0]]       = item_i.value;
      val_pend_d[item_i.index[VidxW-1:0]] = 1'b1;
    end

    if (cmd_i.iv_start) begin
      for (int g = 0; g < STATUS_GROUPS; g++) begin
        if (item_i.index == 5'(g)) st_inv_d[g] = iv_flag;
      end
      for (int g = 0; g < VALUE_GROUPS; g++) begin
        if (item_i.index == 5'(g + 2)) val_inv_d[g] = iv_flag;
      end
      type_d     = iv_type;
      rep_pos_d  = iv_base;
      rep_left_d = iv_left;
    end

    if (cmd_i.scan_start) begin
      type_d       = item_i.op[0];
      ptr_d        = '0;
      run_open_d   = 1'b0;
      held_valid_d = 1'b0;
      k_d          = '0;
    end

    if (cmd_i.scan_step) begin
      if (run_open_q) begin
        if (pend_bit && (run_len_q < 5'(MAX_RUN))) begin
          // extend the run
          if (type_q) val_pend_d[ptr_q[VidxW-1:0]] = 1'b0;
          else        st_pend_d[ptr_q[SidxW-1:0]]  = 1'b0;
          run_len_d = run_len_q + 5'd1;
          ptr_d     = ptr_q + PtrW'(1);
        end else begin
          // close the run; release the previously held one
          if (held_valid_q) begin
            out_valid_d       = 1'b1;
            out_d.point_type  = type_q;
            out_d.first_index = 6'(held_first_q);
            out_d.count       = held_len_q;
            out_d.last        = 1'b0;
          end
          held_valid_d = 1'b1;
          held_first_d = run_first_q;
          held_len_d   = run_len_q;
          run_open_d   = 1'b0;
          k_d          = k_q + 6'd1;
        end
      end else if (scan_stop) begin
        // flush the held run as the final transaction
        if (held_valid_q) begin
          out_valid_d       = 1'b1;
          out_d.point_type  = type_q;
          out_d.first_index = 6'(held_first_q);
          out_d.count       = held_len_q;
          out_d.last        = 1'b1;
        end
        held_valid_d = 1'b0;
      end else if (pend_bit) begin
        if (type_q) val_pend_d[ptr_q[VidxW-1:0]] = 1'b0;
        else        st_pend_d[ptr_q[SidxW-1:0]]  = 1'b0;
        run_open_d  = 1'b1;
        run_first_d = ptr_q;
        run_len_d   = 5'd1;
        ptr_d       = ptr_q + PtrW'(1);
      end else begin
        ptr_d = ptr_q + PtrW'(1);
      end
    end

    if (cmd_i.rep_step) begin
      out_valid_d       = 1'b1;
      out_d.point_type  = type_q;
      out_d.first_index = rep_pos_q;
      out_d.count       = (rep_left_q > LeftW'(IvSpan)) ? 5'(IvSpan) : 5'(rep_left_q);
      out_d.last        = (rep_left_q <= LeftW'(IvSpan));
      rep_left_d        = rep_left_q - LeftW'(IvSpan);
      rep_pos_d         = rep_pos_q + 6'(IvSpan);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < Sb; b++) st_bits_q[b] <= '0;
      for (int v = 0; v < Vt; v++) mv_q[v] <= '0;
      st_pend_q    <= '0;
      st_inv_q     <= '1;
      val_pend_q   <= '0;
      val_inv_q    <= '1;
      type_q       <= 1'b0;
      ptr_q        <= '0;
      run_open_q   <= 1'b0;
      run_len_q    <= '0;
      held_valid_q <= 1'b0;
      k_q          <= '0;
      rep_left_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      st_bits_q    <= st_bits_d;
      mv_q         <= mv_d;
      st_pend_q    <= st_pend_d;
      st_inv_q     <= st_inv_d;
      val_pend_q   <= val_pend_d;
      val_inv_q    <= val_inv_d;
      type_q       <= type_d;
      ptr_q        <= ptr_d;
      run_open_q   <= run_open_d;
      run_len_q    <= run_len_d;
      held_valid_q <= held_valid_d;
      k_q          <= k_d;
      rep_left_q   <= rep_left_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    run_first_q  <= run_first_d;
    held_first_q <= held_first_d;
    held_len_q   <= held_len_d;
    rep_pos_q    <= rep_pos_d;
    out_q        <= out_d;
  end

  assign result_valid_o = out_valid_q;
  assign result_o       = out_q;

endmodule

// File: hw/rtl/change_event_run_reporter.sv
// ----------------------------------------------------------------------------
// change_event_run_reporter
// Change-marked status and value tables with run-length change reporting.
//
//   channel   | ports                          | handshake
//   ----------+--------------------------------+----------------------------
//   command   | start, busy, item_i            | taken when start && !busy
//   result    | result_valid_o, result_o       | one-cycle strobe, no stall
//
// Updates leave busy low. A scan walks the marks one per cycle, with an extra
// step wherever a run closes; the status table holds 64 points. A validity
// change reports its group as 16-entry descriptors, one per cycle. Each
// descriptor is registered before it shows on the result port.
// After reset all tables and marks are clear and every group is invalid.
// ----------------------------------------------------------------------------
module change_event_run_reporter import cerr_pkg::*; #(
  parameter int STATUS_BYTES_PER_GROUP = StatusBytesPerGroupDef,
  parameter int STATUS_GROUPS          = StatusGroupsDef,
  parameter int VALUE_GROUPS           = ValueGroupsDef,
  parameter int MAX_RUN                = MaxRunDef
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start,
  output logic  busy,
  input  item_t item_i,
  output logic  result_valid_o,
  output desc_t result_o
);

  cmd_t cmd;
  sts_t sts;

  cerr_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .op_i   (item_i.op),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  cerr_datapath #(
    .STATUS_BYTES_PER_GROUP(STATUS_BYTES_PER_GROUP),
    .STATUS_GROUPS         (STATUS_GROUPS),
    .VALUE_GROUPS          (VALUE_GROUPS),
    .MAX_RUN               (MAX_RUN)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_i        (item_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

endmodule

// File: hw/rtl/cerr_checker.sv
// ----------------------------------------------------------------------------
// cerr_checker
// Port-level checks of the change-event run reporter, bound to the top level.
// ----------------------------------------------------------------------------
`include "change_event_run_reporter_defines.svh"

module cerr_checker import cerr_pkg::*; (
  input logic  clk_i,
  input logic  rst_ni,
  input logic  start,
  input logic  busy,
  input item_t item_i,
  input logic  result_valid_o,
  input desc_t result_o
);

  logic accept;
  assign accept = start && !busy;

  `CERR_ASSERT_SAME(a_count_range, clk_i, rst_ni, result_valid_o, (result_o.count != 5'd0) && (result_o.count <= 5'd16), "descriptor count out of range")
  `CERR_ASSERT_SAME(a_more_pending, clk_i, rst_ni, result_valid_o && !result_o.last, busy, "non-final descriptor while idle")
  `CERR_ASSERT_NEXT(a_update_single, clk_i, rst_ni, accept && ((item_i.op == OpStatusUpd) || (item_i.op == OpValueUpd)), !busy && !result_valid_o, "update held the block")
  `CERR_ASSERT_NEXT(a_scan_busy, clk_i, rst_ni, accept && ((item_i.op == OpStatusScan) || (item_i.op == OpValueScan)), busy, "scan did not start")

endmodule

bind change_event_run_reporter cerr_checker u_cerr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .item_i        (item_i),
  .result_valid_o(result_valid_o),
  .result_o      (result_o)
);

// File: tb/sv/change_event_checker.sv
// ----------------------------------------------------------------------------
// change_event_checker
// Watches the command and result channels of the change-event run reporter.
// Keeps its own copy of the point tables, pending marks and group flags.
// Works out the descriptors that each accepted command should cause, and
// compares every result strobe with the oldest outstanding descriptor.
// ----------------------------------------------------------------------------
module change_event_checker import cerr_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start,
  input  logic  busy,
  input  item_t item_i,
  input  logic  result_valid_o,
  input  desc_t result_o,
  output int    mismatch_count_o,
  output int    outstanding_o
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int StatusGroupSize = StatusBytesPerGroupDef * 8;
  localparam int StatusPoints    = StatusGroupSize * StatusGroupsDef;
  localparam int StatusByteCount = StatusBytesPerGroupDef * StatusGroupsDef;
  localparam int ValuePoints     = ValuesPerGroup * ValueGroupsDef;
  localparam int StatusChannels  = 2;
  localparam int ValidityChannels = 4;

  localparam logic KindStatus = 1'b0;
  localparam logic KindValue  = 1'b1;

  logic [StatusPoints-1:0] status_bits;
  logic [StatusPoints-1:0] status_pending;
  logic [StatusGroupsDef-1:0] status_invalid;
  logic [15:0] measured [ValuePoints];
  logic [ValuePoints-1:0] value_pending;
  logic [ValueGroupsDef-1:0] value_invalid;

  desc_t expected_desc_q[$];
  int    mismatches;

  assign mismatch_count_o = mismatches;
  assign outstanding_o    = expected_desc_q.size();

  function automatic void push_desc(logic kind, int first, int cnt);
    desc_t d;
    d.point_type  = kind;
    d.first_index = first[5:0];
    d.count       = cnt[4:0];
    d.last        = 1'b0;
    expected_desc_q.push_back(d);
  endfunction

  // Report runs of marked entries and return the marks that stay pending.
  function automatic logic [63:0] scan_marks(logic [63:0] marks, int size, logic kind);
    int i;
    int first;
    int len;
    int n;
    i = 0;
    n = 0;
    while (i < size) begin
      if (!marks[i]) begin
        i++;
      end else if (n >= MaxResults) begin
        break;
      end else begin
        first = i;
        len = 0;
        while (i < size && marks[i] && len < MaxRunDef) begin
          marks[i] = 1'b0;
          len++;
          i++;
        end
        push_desc(kind, first, len);
        n++;
      end
    end
    return marks;
  endfunction

  function automatic void report_group(int base, int gsize, logic kind);
    int n;
    n = 0;
    for (int off = 0; off < gsize && n < MaxResults; off += IvSpan) begin
      push_desc(kind, base + off, (gsize - off > IvSpan) ? IvSpan : gsize - off);
      n++;
    end
  endfunction

  function automatic void predict_descs(item_t it);
    int prior_size;
    int idx;
    int p;
    logic flag;
    logic [63:0] marks;
    prior_size = expected_desc_q.size();
    idx = int'(it.index);
    flag = it.value[0];
    case (it.op)
      OpStatusUpd: begin
        if (idx < StatusByteCount) begin
          for (int j = 0; j < 8; j++) begin
            p = idx * 8 + j;
            if (status_bits[p] != it.value[j]) begin
              status_bits[p] = it.value[j];
              status_pending[p] = 1'b1;
            end
          end
        end
      end
      OpValueUpd: begin
        if (idx < ValuePoints && measured[idx] != it.value) begin
          measured[idx] = it.value;
          value_pending[idx] = 1'b1;
        end
      end
      OpStatusScan: begin
        marks = scan_marks(64'(status_pending), StatusPoints, KindStatus);
        status_pending = marks[StatusPoints-1:0];
      end
      OpValueScan: begin
        marks = scan_marks(64'(value_pending), ValuePoints, KindValue);
        value_pending = marks[ValuePoints-1:0];
      end
      OpValidity: begin
        if (idx < StatusChannels) begin
          if (idx < StatusGroupsDef && status_invalid[idx] != flag) begin
            status_invalid[idx] = flag;
            report_group(idx * StatusGroupSize, StatusGroupSize, KindStatus);
          end
        end else if (idx < ValidityChannels) begin
          if (idx - StatusChannels < ValueGroupsDef &&
              value_invalid[idx - StatusChannels] != flag) begin
            value_invalid[idx - StatusChannels] = flag;
            report_group((idx - StatusChannels) * ValuesPerGroup, ValuesPerGroup, KindValue);
          end
        end
      end
      default: ;
    endcase
    if (expected_desc_q.size() > prior_size) begin
      expected_desc_q[expected_desc_q.size() - 1].last = 1'b1;
    end
  endfunction

  function automatic void check_field(string name, int exp_val, int act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    desc_t exp_desc;
    if (!rst_ni) begin
      status_bits    = '0;
      status_pending = '0;
      status_invalid = '1;
      value_pending  = '0;
      value_invalid  = '1;
      for (int i = 0; i < ValuePoints; i++) measured[i] = '0;
      expected_desc_q.delete();
      mismatches = 0;
    end else begin
      // A strobe seen here always belongs to an earlier transaction.
      if (result_valid_o) begin
        if (expected_desc_q.size() == 0) begin
          $error("descriptor with none outstanding: type %0d first %0d count %0d last %0d",
                 result_o.point_type, result_o.first_index, result_o.count, result_o.last);
          mismatches++;
        end else begin
          exp_desc = expected_desc_q.pop_front();
          check_field("point_type", exp_desc.point_type, result_o.point_type);
          check_field("first_index", exp_desc.first_index, result_o.first_index);
          check_field("count", exp_desc.count, result_o.count);
          check_field("last", exp_desc.last, result_o.last);
        end
      end
      if (start && !busy) predict_descs(item_i);
    end
  end

endmodule

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the change-event run reporter.
// Drives a directed set of updates, scans and validity changes, then a long
// random mix with idle bursts; the checker predicts and compares descriptors.
// ----------------------------------------------------------------------------
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  import cerr_pkg::*;

  localparam logic [2:0] OpFirstUnused = OpValidity + 3'd1;
  localparam logic [4:0] ChanStatus0   = 5'd0;
  localparam logic [4:0] ChanValue0    = 5'd2;
  localparam logic [4:0] ChanValue1    = 5'd3;
  localparam logic [4:0] ChanFirstNone = 5'd4;
  localparam int StatusByteCount = StatusBytesPerGroupDef * StatusGroupsDef;
  localparam int ValuePoints     = ValuesPerGroup * ValueGroupsDef;
  localparam int RandomItems     = 300;
  localparam int QuietTail       = 50;
  localparam int DrainLimit      = 5000;
  localparam int SettleCycles    = 120;

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  start = 1'b0;
  logic  busy;
  item_t item_i = '0;
  logic  result_valid_o;
  desc_t result_o;
  int    mismatch_count;
  int    outstanding;
  bit    idling_on;

  always #10 clk_i = ~clk_i;

  change_event_run_reporter u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .item_i        (item_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  change_event_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .item_i          (item_i),
    .result_valid_o  (result_valid_o),
    .result_o        (result_o),
    .mismatch_count_o(mismatch_count),
    .outstanding_o   (outstanding)
  );

  task automatic send_cmd(logic [2:0] op, logic [4:0] index, logic [15:0] value);
    item_t it;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 6)) begin
        @(negedge clk_i);
        start <= 1'b0;
      end
    end
    it.op    = op;
    it.index = index;
    it.value = value;
    @(negedge clk_i);
    start  <= 1'b1;
    item_i <= it;
    // Hold until the block takes the transaction.
    do @(posedge clk_i); while (busy);
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    @(negedge clk_i);
    start <= 1'b0;
    while (outstanding != 0 && guard < DrainLimit) begin
      @(posedge clk_i);
      guard++;
    end
  endtask

  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int done;
    int r;
    logic [15:0] v;
    idling_on = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part: validity, group boundaries, run splits, ignored commands.
    send_cmd(OpValidity, ChanStatus0, 16'h0001);
    send_cmd(OpValidity, ChanStatus0, 16'hFFFE);
    send_cmd(OpValidity, ChanValue1, 16'h0000);
    send_cmd(OpValidity, ChanFirstNone, 16'h0000);
    send_cmd(OpValidity, 5'd31, 16'hFFFF);
    send_cmd(OpStatusUpd, 5'd0, 16'h0001);
    send_cmd(OpStatusUpd, 5'd3, 16'hFFFF);
    send_cmd(OpStatusUpd, 5'd4, 16'h00FF);
    send_cmd(OpStatusUpd, 5'(StatusByteCount - 1), 16'h0080);
    send_cmd(OpStatusUpd, 5'(StatusByteCount), 16'h00FF);
    send_cmd(OpStatusUpd, 5'd31, 16'h00FF);
    send_cmd(OpStatusScan, 5'd0, 16'h0000);
    for (int b = 0; b < StatusByteCount; b++) send_cmd(OpStatusUpd, 5'(b), 16'h5555);
    send_cmd(OpStatusScan, 5'd31, 16'hFFFF);
    send_cmd(OpValueUpd, 5'd0, 16'hFFFF);
    send_cmd(OpValueUpd, 5'd15, 16'h0001);
    send_cmd(OpValueUpd, 5'd16, 16'h0001);
    send_cmd(OpValueUpd, 5'(ValuePoints - 1), 16'h8000);
    send_cmd(OpValueUpd, 5'd0, 16'hFFFF);
    send_cmd(OpFirstUnused, 5'd0, 16'h0000);
    send_cmd(3'(OpFirstUnused + 3'd2), 5'd31, 16'hFFFF);
    send_cmd(OpValueScan, 5'd0, 16'h0000);
    send_cmd(OpValueScan, 5'd0, 16'h0000);

    // Random part.
    done = 0;
    while (done < RandomItems) begin
      idling_on = (done < RandomItems - QuietTail);
      if (done == RandomItems / 2) wait_drained();
      r = $urandom_range(0, 99);
      if (r < 35) begin
        case ($urandom_range(0, 3))
          0: v = 16'h00FF | 16'($urandom_range(0, 255) << 8);
          1: v = 16'($urandom_range(0, 255) << 8);
          default: v = 16'($urandom);
        endcase
        send_cmd(OpStatusUpd, 5'($urandom_range(0, StatusByteCount - 1)), v);
        done++;
      end else if (r < 65) begin
        v = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 3)) : 16'($urandom);
        send_cmd(OpValueUpd, 5'($urandom_range(0, ValuePoints - 1)), v);
        done++;
      end else if (r < 77) begin
        send_cmd(OpStatusScan, 5'($urandom), 16'($urandom));
        done++;
      end else if (r < 89) begin
        send_cmd(OpValueScan, 5'($urandom), 16'($urandom));
        done++;
      end else if (r < 95) begin
        send_cmd(OpValidity, 5'($urandom_range(ChanStatus0, ChanValue1)), 16'($urandom));
        done++;
      end else begin
        // Noise: dropped by the block, not counted.
        case ($urandom_range(0, 2))
          0: send_cmd(3'($urandom_range(OpFirstUnused, 7)), 5'($urandom), 16'($urandom));
          1: send_cmd(OpStatusUpd, 5'($urandom_range(StatusByteCount, 31)), 16'($urandom));
          default: send_cmd(OpValidity, 5'($urandom_range(ChanFirstNone, 31)),
                            16'($urandom));
        endcase
      end
    end

    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      if (outstanding != 0) $error("%0d descriptors never arrived", outstanding);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
